>>> design/sorted_table_nearest_key_lookup_assert.svh
// Assertion macros for the sorted key table.
// Included by the top level; relies on its clock and reset signal names.
`ifndef SORTED_TABLE_NEAREST_KEY_LOOKUP_ASSERT_SVH
`define SORTED_TABLE_NEAREST_KEY_LOOKUP_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define STNKL_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Checks that one condition implies another in the same cycle.
`define STNKL_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> design/stnkl_pkg.sv
// Package for the sorted key table: sizes, codes, commands, states, link types.
// Used by the table cell, the top level and the bench; depends on nothing else.
package stnkl_pkg;

   localparam int DEPTH     = 16;
   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 16;
   localparam int STATUS_W  = 2;
   localparam int CNT_W     = $clog2(DEPTH + 1);

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_COMPARE,
      CMD_PICK
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_PICK,
      ST_SELECT
   } state_type;

   typedef struct packed {
      logic                 valid;
      logic                 place;
      logic                 ge;
      logic                 closer;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } cell_link_type;

endpackage

>>> design/stnkl_cell.sv
// One entry of the sorted key table, with its insert shift and lookup compare logic.
// Depends on stnkl_pkg; instantiated in a row by the top level.
module stnkl_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  stnkl_pkg::cell_cmd_type        cmd,
   input  logic [stnkl_pkg::KEY_W-1:0]    new_key,
   input  logic [stnkl_pkg::PAYLOAD_W-1:0] new_payload,
   input  stnkl_pkg::cell_link_type       prev_link,
   input  stnkl_pkg::cell_link_type       next_link,
   output stnkl_pkg::cell_link_type       link,
   output logic                           pick
);
   import stnkl_pkg::*;

   logic                 valid_ff, valid_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic                 ge_ff, ge_in;
   logic [KEY_W-1:0]     above_ff, above_in;
   logic [KEY_W-1:0]     below_ff, below_in;
   logic                 pick_ff, pick_in;
   logic                 place;
   logic                 cand;
   logic                 closer;

   // An entry makes room for a new key when it is empty or holds a greater key.
   assign place  = !valid_ff || (key_ff > new_key);
   assign cand   = ge_ff && !prev_link.ge;
   assign closer = cand && prev_link.valid && (below_ff < above_ff);

   always_comb begin
      valid_in   = valid_ff;
      key_in     = key_ff;
      payload_in = payload_ff;
      ge_in      = ge_ff;
      above_in   = above_ff;
      below_in   = below_ff;
      pick_in    = pick_ff;
      case (cmd)
         CMD_INSERT: begin
            if (place) begin
               if (prev_link.place) begin
                  valid_in   = prev_link.valid;
                  key_in     = prev_link.key;
                  payload_in = prev_link.payload;
               end else begin
                  valid_in   = 1'b1;
                  key_in     = new_key;
                  payload_in = new_payload;
               end
            end
         end
         CMD_COMPARE: begin
            ge_in    = valid_ff && (key_ff >= new_key);
            above_in = key_ff - new_key;
            below_in = new_key - prev_link.key;
         end
         CMD_PICK: begin
            pick_in = (cand && !closer) || next_link.closer
                      || (valid_ff && !next_link.valid && !ge_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
      ge_ff      <= ge_in;
      above_ff   <= above_in;
      below_ff   <= below_in;
      pick_ff    <= pick_in;
   end

   assign link.valid   = valid_ff;
   assign link.place   = place;
   assign link.ge      = ge_ff;
   assign link.closer  = closer;
   assign link.key     = key_ff;
   assign link.payload = payload_ff;
   assign pick         = pick_ff;

endmodule

>>> design/sorted_table_nearest_key_lookup.sv
// Top level of the sorted key table with nearest-key lookup.
// Depends on stnkl_pkg, stnkl_cell and sorted_table_nearest_key_lookup_assert.svh.
//
// The table is a row of cells, one per entry, kept in ascending key order. One
// item is worked on at a time, and its result waits to enter the output register
// while that register is full. A refused insert or a lookup on an empty table goes
// straight to its result. An insert shifts all greater entries up at once; a
// lookup compares every entry with the query, then chooses the nearest entry with
// its neighbour, then gathers the result into the output register. A finished
// result waits in that register while the next item is taken.
module sorted_table_nearest_key_lookup (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // key [31:0], payload [47:32]
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // match_key [31:0], match_payload [47:32]
   output logic [1:0]  rsp_tuser    // status
);
   import stnkl_pkg::*;

   state_type            state_ff, state_in;
   logic                 func_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [PAYLOAD_W-1:0] payload_ff;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [47:0]          rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]  rsp_user_ff;
   cell_cmd_type         cmd;
   logic                 accept;
   logic                 load;
   logic                 result_done;

   cell_link_type        link [DEPTH];
   cell_link_type        prev_link [DEPTH];
   cell_link_type        next_link [DEPTH];
   logic [DEPTH-1:0]     pick;
   logic [DEPTH-1:0]     valid_vec;
   logic [KEY_W-1:0]     sel_key;
   logic [PAYLOAD_W-1:0] sel_payload;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prev_link[i] = '0;
      end else begin : g_inner
         assign prev_link[i] = link[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_link[i] = '0;
      end else begin : g_body
         assign next_link[i] = link[i+1];
      end
      assign valid_vec[i] = link[i].valid;

      stnkl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_key     (key_ff),
         .new_payload (payload_ff),
         .prev_link   (prev_link[i]),
         .next_link   (next_link[i]),
         .link        (link[i]),
         .pick        (pick[i])
      );
   end

   assign accept = req_tvalid && req_tready;
   assign load   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      status_in = STATUS_OK;
      if (req_tuser == FUNC_INSERT) begin
         if (count_ff == CNT_W'(DEPTH)) begin
            status_in = STATUS_FULL;
         end
      end else if (count_ff == '0) begin
         status_in = STATUS_EMPTY;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (status_in == STATUS_OK) ? ST_COMPARE : ST_SELECT;
            end
         end
         ST_COMPARE: begin
            state_in = (func_ff == FUNC_LOOKUP) ? ST_PICK : ST_SELECT;
         end
         ST_PICK: begin
            state_in = ST_SELECT;
         end
         ST_SELECT: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd         = CMD_HOLD;
      result_done = 1'b0;
      count_in    = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_COMPARE: begin
            if (func_ff == FUNC_LOOKUP) begin
               cmd = CMD_COMPARE;
            end else begin
               cmd      = CMD_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_PICK: begin
            cmd = CMD_PICK;
         end
         ST_SELECT: begin
            result_done = load;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      sel_key     = '0;
      sel_payload = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_key     = sel_key | (link[i].key & {KEY_W{pick[i]}});
         sel_payload = sel_payload | (link[i].payload & {PAYLOAD_W{pick[i]}});
      end
      rsp_data_in = '0;
      if (func_ff == FUNC_LOOKUP && status_ff == STATUS_OK) begin
         rsp_data_in = {sel_payload, sel_key};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (result_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= req_tuser;
         key_ff     <= req_tdata[KEY_W-1:0];
         payload_ff <= req_tdata[KEY_W+PAYLOAD_W-1:KEY_W];
         status_ff  <= status_in;
      end
      if (result_done) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`include "sorted_table_nearest_key_lookup_assert.svh"

   `STNKL_ALWAYS(a_count_range, count_ff <= CNT_W'(DEPTH), "Entry count exceeds the table depth.")
   `STNKL_ALWAYS(a_count_matches, $countones(valid_vec) == count_ff, "Valid entries disagree with the entry count.")
   `STNKL_IMPLIES(a_pick_onehot, state_ff == ST_SELECT && func_ff == FUNC_LOOKUP && status_ff == STATUS_OK, $onehot(pick), "A lookup did not select exactly one entry.")
   `STNKL_IMPLIES(a_busy_not_ready, state_ff != ST_IDLE, !req_tready, "An item was offered acceptance while another is in progress.")

endmodule

>>> tb/sv/tb.sv
// Self-checking bench for the sorted key table with nearest-key lookup.
// Drives directed and random inserts and lookups, predicts each answer in a small
// scoreboard class and compares every result; depends on stnkl_pkg and the top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import stnkl_pkg::*;

   localparam int RANDOM_ITEMS = 1330;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } answer_type;

   class table_scoreboard;
      logic [KEY_W-1:0]     keys [DEPTH];
      logic [PAYLOAD_W-1:0] payloads [DEPTH];
      int unsigned          fill;
      answer_type           expected_answers [$];
      int unsigned          mismatches;

      function new();
         fill = 0;
         mismatches = 0;
      endfunction

      // Updates the tracked table and queues the answer the block owes.
      function void note_request(logic func, logic [KEY_W-1:0] key,
                                 logic [PAYLOAD_W-1:0] payload);
         answer_type       ans;
         int unsigned      pos;
         logic [KEY_W-1:0] below_gap;
         logic [KEY_W-1:0] above_gap;
         ans = '0;
         if (func == FUNC_INSERT) begin
            if (fill >= DEPTH) begin
               ans.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < fill && key >= keys[pos]) pos++;
               for (int i = fill; i > pos; i--) begin
                  keys[i] = keys[i-1];
                  payloads[i] = payloads[i-1];
               end
               keys[pos] = key;
               payloads[pos] = payload;
               fill++;
               ans.status = STATUS_OK;
            end
         end else if (fill == 0) begin
            ans.status = STATUS_EMPTY;
         end else begin
            pos = 0;
            while (pos < fill && key > keys[pos]) pos++;
            if (pos == fill) begin
               pos = fill - 1;
            end else if (pos != 0) begin
               below_gap = key - keys[pos-1];
               above_gap = keys[pos] - key;
               if (below_gap < above_gap) pos--;
            end
            ans.status = STATUS_OK;
            ans.key = keys[pos];
            ans.payload = payloads[pos];
         end
         expected_answers.push_back(ans);
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [KEY_W-1:0] key,
                                 logic [PAYLOAD_W-1:0] payload);
         answer_type ans;
         if (expected_answers.size() == 0) begin
            $error("result with no item waiting: status %0d, match_key %h", status, key);
            mismatches++;
            return;
         end
         ans = expected_answers.pop_front();
         if (status !== ans.status) begin
            $error("status: expected %0d, actual %0d", ans.status, status);
            mismatches++;
         end
         if (key !== ans.key) begin
            $error("match_key: expected %h, actual %h", ans.key, key);
            mismatches++;
         end
         if (payload !== ans.payload) begin
            $error("match_payload: expected %h, actual %h", ans.payload, payload);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [47:0]          req_tdata;    // key [31:0], payload [47:32]
   logic                 req_tuser;    // func
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [47:0]          rsp_tdata;    // match_key [31:0], match_payload [47:32]
   logic [STATUS_W-1:0]  rsp_tuser;    // status

   table_scoreboard sb;
   bit              req_steady;
   bit              rsp_steady;
   int unsigned     cycle_count;

   sorted_table_nearest_key_lookup DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input logic func, input logic [KEY_W-1:0] key,
                            input logic [PAYLOAD_W-1:0] payload);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) req_steady = !req_steady;
      gap = req_steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {payload, key};
      do @(posedge clock); while (!req_tready);
      sb.note_request(func, key, payload);
      @(negedge clock);
   endtask

   // Lookups dominate, with inserts mixed in until the table is full and refused
   // now and then after that; lookups aim at stored keys, their neighbourhoods,
   // the midpoints between neighbours (rounded down), random keys and both range ends.
   task automatic send_random_item();
      logic             func;
      logic [KEY_W-1:0] key;
      int unsigned      pick;
      int unsigned      slot;
      pick = $urandom_range(0, 99);
      func = (sb.fill < DEPTH) ? (pick >= 25) : (pick >= 6);
      if (func == FUNC_INSERT) begin
         case ($urandom_range(0, 2))
            0: key = $urandom;
            1: key = $urandom_range(0, 255);
            default: begin
               if (sb.fill == 0) key = $urandom;
               else key = sb.keys[$urandom_range(0, sb.fill - 1)];
            end
         endcase
      end else begin
         slot = (sb.fill == 0) ? 0 : $urandom_range(0, sb.fill - 1);
         case ($urandom_range(0, 6))
            0: key = $urandom;
            1: key = sb.keys[slot];
            2: key = sb.keys[slot] + $urandom_range(0, 3);
            3: key = sb.keys[slot] - $urandom_range(0, 3);
            4: begin
               if (sb.fill < 2) begin
                  key = $urandom;
               end else begin
                  slot = $urandom_range(0, sb.fill - 2);
                  key = sb.keys[slot] + (sb.keys[slot+1] - sb.keys[slot]) / 2;
               end
            end
            5: key = '0;
            default: key = '1;
         endcase
      end
      send_item(func, key, PAYLOAD_W'($urandom));
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = FUNC_INSERT;
      rsp_tready = 1'b0;
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(FUNC_LOOKUP, 32'h0000_0000, 16'hFFFF);
      send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
      send_item(FUNC_INSERT, 32'd1000, 16'h0001);
      send_item(FUNC_LOOKUP, 32'h0000_0000, 16'h0000);
      send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(FUNC_INSERT, 32'h0000_0000, 16'hFFFF);
      send_item(FUNC_INSERT, 32'hFFFF_FFFF, 16'h8000);
      send_item(FUNC_INSERT, 32'd2000, 16'h1234);
      send_item(FUNC_INSERT, 32'd1000, 16'hABCD);
      send_item(FUNC_LOOKUP, 32'd1000, 16'h0000);
      send_item(FUNC_LOOKUP, 32'd1500, 16'h0000);
      send_item(FUNC_LOOKUP, 32'd1499, 16'h0000);
      send_item(FUNC_LOOKUP, 32'd1501, 16'h0000);
      send_item(FUNC_LOOKUP, 32'h0000_0000, 16'h0000);
      send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
      send_item(FUNC_LOOKUP, 32'h8000_0000, 16'h0000);
      send_item(FUNC_LOOKUP, 32'hFFFF_F000, 16'h0000);
      send_item(FUNC_INSERT, 32'h0000_0000, 16'h5555);
      send_item(FUNC_LOOKUP, 32'h0000_0001, 16'h0000);
      send_item(FUNC_LOOKUP, 32'h0000_0000, 16'h0000);

      repeat (RANDOM_ITEMS) send_random_item();
      req_tvalid <= 1'b0;

      while (sb.expected_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("sorted_table_nearest_key_lookup regression: pass");
      end else begin
         $display("sorted_table_nearest_key_lookup regression: fail");
      end
      $finish;
   end

   initial begin
      int unsigned stall;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_steady = !rsp_steady;
         stall = rsp_steady ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tuser, rsp_tdata[31:0], rsp_tdata[47:32]);
         @(negedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sorted_table_nearest_key_lookup regression: fail");
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/stnkl_pkg.sv
design/stnkl_cell.sv
design/sorted_table_nearest_key_lookup.sv
tb/sv/tb.sv
